[rtl/lbgt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgt_pkg
// Shared types, widths and codes of the linear layer batch gradient trainer.
// ----------------------------------------------------------------------------
package lbgt_pkg;

    localparam int VEC_LEN_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 20;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 5;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 5;
    localparam int GRAD_W   = 48;
    localparam int X_W      = 17;
    localparam int PROD_W   = GRAD_W + X_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_TRAIN    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE = 1'd1;

    localparam logic [15:0] BATCH_SIZE_RST = 16'd1000;
    localparam logic [31:0] STEP_SCALE_RST = 32'd42950;

    localparam logic [COL_W-1:0] BIAS_COL = 5'd16;

    // -1000.0 in Q16.16
    localparam logic signed [VAL_W-1:0] SCORE_START = -32'sd65536000;

    typedef struct packed {
        logic                     en;
        logic signed [GRAD_W-1:0] a;
        logic [X_W-1:0]           b;
    } mul_req_t;

endpackage

[rtl/lbgt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgt_if
// Valid/ready channels for request and response words of the trainer.
// ----------------------------------------------------------------------------
interface lbgt_req_if;
    import lbgt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [SAMPLE_W-1:0]     sample_value;
    logic [ROW_W-1:0]        target_row;
    logic [COL_W-1:0]        target_col;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, mode, sample_value, target_row, target_col, write_value,
                    input ready);
    modport sink (input valid, mode, sample_value, target_row, target_col, write_value,
                  output ready);
endinterface

interface lbgt_rsp_if;
    import lbgt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        predicted_index;
    logic signed [VAL_W-1:0] best_score;
    logic                    batch_done;

    modport source (output valid, predicted_index, best_score, batch_done, input ready);
    modport sink (input valid, predicted_index, best_score, batch_done, output ready);
endinterface

[rtl/lbgt_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbgt_mul
// Shared registered multiplier: signed 48 bit by unsigned 17 bit.
// ----------------------------------------------------------------------------
module lbgt_mul
(
    input  logic                                 clk,
    input  lbgt_pkg::mul_req_t                   req,
    output logic signed [lbgt_pkg::PROD_W-1:0]   prod
);
    import lbgt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = req.a * $signed({1'b0, req.b});

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/linear_layer_batch_gradient_trainer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_layer_batch_gradient_trainer
// Linear layer trained by batch gradient descent on two-hot samples.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req      in   mode, sample_value, target_row, target_col, write_value
// rsp      out  predicted_index, best_score, batch_done
// cfg      in   cfg_wen, cfg_index, cfg_data (batch_size, step_scale)
//
// One multiplier, and one read and one write port on each memory, serve
// every step. A classify word scores each row; a train word also updates
// the gradients, and when it closes a batch it updates every memory entry
// (2^(RW+CW), 512 at VEC_LEN 16). After reset a clearing pass over every
// entry zeroes weights and gradients; req.ready stays low.
// A full response register holds the next word in its final step.
// ----------------------------------------------------------------------------
module linear_layer_batch_gradient_trainer
#(
    parameter int VEC_LEN = lbgt_pkg::VEC_LEN_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    lbgt_req_if.sink                            req,
    lbgt_rsp_if.source                          rsp,
    input  logic                                cfg_wen,
    input  logic [lbgt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lbgt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lbgt_pkg::*;

    localparam int RW    = $clog2(VEC_LEN);
    localparam int CW    = $clog2(VEC_LEN + 1);
    localparam int AW    = RW + CW;
    localparam int ACC_W = 51;
    localparam int Y_W   = 52;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_CLEAR = 14'b00000000000010,
        ST_T_RD  = 14'b00000000000100,
        ST_T_MUL = 14'b00000000001000,
        ST_T_ACC = 14'b00000000010000,
        ST_T_BIAS= 14'b00000000100000,
        ST_G_RD  = 14'b00000001000000,
        ST_G_WR  = 14'b00000010000000,
        ST_B_WR  = 14'b00000100000000,
        ST_U_RD  = 14'b00001000000000,
        ST_U_M1  = 14'b00010000000000,
        ST_U_M2  = 14'b00100000000000,
        ST_U_WR  = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // memories: weights and biases share one, bias at column VEC_LEN
    logic [VAL_W-1:0]  wt_mem [2**AW];
    logic [GRAD_W-1:0] gr_mem [2**AW];
    logic [VAL_W-1:0]  wrd_reg;
    logic [GRAD_W-1:0] grd_reg;

    logic              w_we, g_we;
    logic [AW-1:0]     w_waddr, g_waddr, w_raddr, g_raddr;
    logic [VAL_W-1:0]  w_wdata;
    logic [GRAD_W-1:0] g_wdata;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                tap_reg, tap_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [GRAD_W-1:0] err_reg, err_next;
    logic signed [PROD_W-1:0] part_reg, part_next;
    logic signed [VAL_W-1:0]  whold_reg, whold_next;
    logic signed [GRAD_W-1:0] ghold_reg, ghold_next;
    logic signed [VAL_W-1:0]  best_reg, best_next;
    logic [RW:0]              idx_reg, idx_next;
    logic                     batch_reg, batch_next;
    logic [15:0]              seen_reg, seen_next;
    logic [15:0]              bsize_reg;
    logic [31:0]              scale_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic signed [VAL_W-1:0]  out_score_reg, out_score_next;
    logic                     out_batch_reg, out_batch_next;

    mul_req_t                 mreq;
    logic signed [PROD_W-1:0] prod;

    lbgt_mul u_mul
    (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // sample decode
    logic [X_W-1:0]   x0, x1, xsel;
    logic [3:0]       c0;
    logic [4:0]       c1, csel;
    logic [4:0]       tgt;
    logic [SAMPLE_W:0] tsum;
    logic             tap_ok;
    logic [AW-1:0]    tap_addr, bias_addr;
    logic             last_row, tgt_hit;

    assign x1   = {1'b0, smp_reg[15:0]};
    assign x0   = 17'h10000 - x1;
    assign c0   = smp_reg[19:16];
    assign c1   = {1'b0, c0} + 5'd1;
    assign tsum = {1'b0, smp_reg} + 21'h08000;
    assign tgt  = tsum[20:16];
    assign csel = tap_reg ? c1 : {1'b0, c0};
    assign xsel = tap_reg ? x1 : x0;
    assign tap_ok    = 32'(csel) < VEC_LEN;
    assign tap_addr  = {row_reg, CW'(csel)};
    assign bias_addr = {row_reg, CW'(VEC_LEN)};
    assign last_row  = row_reg == RW'(VEC_LEN - 1);
    assign tgt_hit   = 32'(row_reg) == 32'(tgt);

    // row output and error
    logic signed [Y_W-1:0]   yhat, err_full;
    logic signed [VAL_W-1:0] score;
    assign yhat     = Y_W'($signed(wrd_reg)) + Y_W'(acc_reg >>> 16);
    assign err_full = yhat - (tgt_hit ? Y_W'(65536) : Y_W'(0));
    assign score    = (yhat[Y_W-1:VAL_W-1] == {(Y_W-VAL_W+1){yhat[Y_W-1]}})
                      ? yhat[VAL_W-1:0]
                      : (yhat[Y_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // gradient accumulation
    logic signed [PROD_W:0]   gsum;
    logic signed [GRAD_W:0]   bsum;
    logic signed [GRAD_W-1:0] gsat, bsat;
    assign gsum = (PROD_W+1)'($signed(grd_reg)) + (PROD_W+1)'(prod >>> 16);
    assign bsum = (GRAD_W+1)'($signed(grd_reg)) + (GRAD_W+1)'(err_reg);
    assign gsat = (gsum[PROD_W:GRAD_W-1] == {(PROD_W-GRAD_W+2){gsum[PROD_W]}})
                  ? gsum[GRAD_W-1:0]
                  : {gsum[PROD_W], {(GRAD_W-1){~gsum[PROD_W]}}};
    assign bsat = (bsum[GRAD_W] == bsum[GRAD_W-1])
                  ? bsum[GRAD_W-1:0]
                  : {bsum[GRAD_W], {(GRAD_W-1){~bsum[GRAD_W]}}};

    // weight update: delta = floor(g * scale / 2^32)
    logic signed [PROD_W:0]   dsum;
    logic signed [PROD_W+1:0] nval;
    logic signed [VAL_W-1:0]  nsat;
    assign dsum = (PROD_W+1)'(part_reg) + (PROD_W+1)'(prod >>> 16);
    assign nval = (PROD_W+2)'(whold_reg) - (PROD_W+2)'(dsum >>> 16);
    assign nsat = (nval[PROD_W+1:VAL_W-1] == {(PROD_W-VAL_W+3){nval[PROD_W+1]}})
                  ? nval[VAL_W-1:0]
                  : (nval[PROD_W+1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // batch bookkeeping
    logic [15:0] seen_inc, need;
    assign seen_inc = (seen_reg == 16'hFFFF) ? seen_reg : seen_reg + 16'd1;
    assign need     = (bsize_reg == 16'd0) ? 16'd1 : bsize_reg;

    logic req_acc, out_free;
    logic wr_row_ok, wr_col16, wr_col_ok;
    assign req.ready = state_reg == ST_IDLE;
    assign req_acc   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign wr_row_ok = 32'(req.target_row) < VEC_LEN;
    assign wr_col16  = req.target_col == BIAS_COL;
    assign wr_col_ok = 32'(req.target_col) < VEC_LEN;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        smp_next       = smp_reg;
        row_next       = row_reg;
        tap_next       = tap_reg;
        addr_next      = addr_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        part_next      = part_reg;
        whold_next     = whold_reg;
        ghold_next     = ghold_reg;
        best_next      = best_reg;
        idx_next       = idx_reg;
        batch_next     = batch_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_idx_next   = out_idx_reg;
        out_score_next = out_score_reg;
        out_batch_next = out_batch_reg;
        w_we    = 1'b0;
        g_we    = 1'b0;
        w_waddr = addr_reg;
        g_waddr = addr_reg;
        w_wdata = '0;
        g_wdata = '0;
        w_raddr = addr_reg;
        g_raddr = addr_reg;
        mreq.en = 1'b0;
        mreq.a  = ghold_reg;
        mreq.b  = xsel;

        case (state_reg)
            ST_CLEAR:
            begin
                w_we = 1'b1;
                g_we = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    mode_next  = req.mode;
                    smp_next   = req.sample_value;
                    row_next   = '0;
                    tap_next   = 1'b0;
                    acc_next   = '0;
                    best_next  = SCORE_START;
                    idx_next   = (RW+1)'(VEC_LEN);
                    batch_next = 1'b0;
                    case (req.mode)
                        MODE_TRAIN, MODE_CLASSIFY: state_next = ST_T_RD;
                        MODE_WRITE:
                        begin
                            w_we    = wr_row_ok && (wr_col16 || wr_col_ok);
                            w_waddr = {RW'(req.target_row),
                                       wr_col16 ? CW'(VEC_LEN) : CW'(req.target_col)};
                            w_wdata = req.write_value;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_T_RD:
            begin
                w_raddr    = tap_addr;
                state_next = ST_T_MUL;
            end
            ST_T_MUL:
            begin
                mreq.en    = 1'b1;
                mreq.a     = tap_ok ? GRAD_W'($signed(wrd_reg)) : '0;
                state_next = ST_T_ACC;
            end
            ST_T_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                if (!tap_reg)
                begin
                    tap_next   = 1'b1;
                    state_next = ST_T_RD;
                end
                else
                begin
                    w_raddr    = bias_addr;
                    state_next = ST_T_BIAS;
                end
            end
            ST_T_BIAS:
            begin
                tap_next = 1'b0;
                acc_next = '0;
                if (mode_reg == MODE_CLASSIFY)
                begin
                    if (score > best_reg)
                    begin
                        best_next = score;
                        idx_next  = {1'b0, row_reg};
                    end
                    if (last_row)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = ST_T_RD;
                    end
                end
                else
                begin
                    err_next   = GRAD_W'(err_full);
                    state_next = ST_G_RD;
                end
            end
            ST_G_RD:
            begin
                g_raddr    = tap_addr;
                mreq.en    = 1'b1;
                mreq.a     = err_reg;
                state_next = ST_G_WR;
            end
            ST_G_WR:
            begin
                g_we    = tap_ok;
                g_waddr = tap_addr;
                g_wdata = gsat;
                if (!tap_reg)
                begin
                    tap_next   = 1'b1;
                    state_next = ST_G_RD;
                end
                else
                begin
                    g_raddr    = bias_addr;
                    state_next = ST_B_WR;
                end
            end
            ST_B_WR:
            begin
                g_we     = 1'b1;
                g_waddr  = bias_addr;
                g_wdata  = bsat;
                tap_next = 1'b0;
                if (!last_row)
                begin
                    row_next   = row_reg + RW'(1);
                    state_next = ST_T_RD;
                end
                else if (seen_inc >= need)
                begin
                    seen_next  = '0;
                    batch_next = 1'b1;
                    addr_next  = '0;
                    state_next = ST_U_RD;
                end
                else
                begin
                    seen_next  = seen_inc;
                    state_next = ST_DONE;
                end
            end
            ST_U_RD:
            begin
                state_next = ST_U_M1;
            end
            ST_U_M1:
            begin
                whold_next = wrd_reg;
                ghold_next = grd_reg;
                mreq.en    = 1'b1;
                mreq.a     = grd_reg;
                mreq.b     = {1'b0, scale_reg[31:16]};
                state_next = ST_U_M2;
            end
            ST_U_M2:
            begin
                part_next  = prod;
                mreq.en    = 1'b1;
                mreq.a     = ghold_reg;
                mreq.b     = {1'b0, scale_reg[15:0]};
                state_next = ST_U_WR;
            end
            ST_U_WR:
            begin
                w_we    = 1'b1;
                w_wdata = nsat;
                g_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == {AW{1'b1}})
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_U_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = (mode_reg == MODE_CLASSIFY) ? IDX_W'(idx_reg) : '0;
                    out_score_next = (mode_reg == MODE_CLASSIFY) ? best_reg : '0;
                    out_batch_next = batch_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wt_mem[w_waddr] <= w_wdata;
        end
        wrd_reg <= wt_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gr_mem[g_waddr] <= g_wdata;
        end
        grd_reg <= gr_mem[g_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            seen_reg      <= '0;
            batch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bsize_reg     <= BATCH_SIZE_RST;
            scale_reg     <= STEP_SCALE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            seen_reg      <= seen_next;
            batch_reg     <= batch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_BATCH_SIZE: bsize_reg <= cfg_data[15:0];
                    CFG_STEP_SCALE: scale_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        smp_reg       <= smp_next;
        row_reg       <= row_next;
        tap_reg       <= tap_next;
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        part_reg      <= part_next;
        whold_reg     <= whold_next;
        ghold_reg     <= ghold_next;
        best_reg      <= best_next;
        idx_reg       <= idx_next;
        out_idx_reg   <= out_idx_next;
        out_score_reg <= out_score_next;
        out_batch_reg <= out_batch_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.predicted_index = out_idx_reg;
    assign rsp.best_score      = out_score_reg;
    assign rsp.batch_done      = out_batch_reg;

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the final step");

    a_req_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != ST_IDLE)
        else $error("accepted word did not start work");

    a_batch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.batch_done |-> rsp.predicted_index == '0 && rsp.best_score == '0)
        else $error("batch word carries classify fields");

endmodule

[tb/linear_layer_batch_gradient_trainer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_layer_batch_gradient_trainer_tb
// Drives train, classify, weight write and unused-mode words into the
// trainer under several batch sizes and step scales and with random idle
// and stall patterns. A local model of the weights, biases and gradient
// stores predicts every response word, which is then compared field by field.
// ----------------------------------------------------------------------------
module linear_layer_batch_gradient_trainer_tb;
    import lbgt_pkg::*;

    localparam int  NROW      = 16;
    localparam int  WATCHDOG  = 40000;
    localparam longint GRAD_HI = 64'sd140737488355327;
    localparam longint GRAD_LO = -GRAD_HI - 1;
    localparam longint ONE_Q  = 65536;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SAMPLE_W-1:0]     sample;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] wval;
    } req_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] score;
        logic                    done;
    } rsp_word_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lbgt_req_if req_ch();
    lbgt_rsp_if rsp_ch();

    linear_layer_batch_gradient_trainer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // layer state as the block should hold it
    logic signed [31:0] layer_w [NROW*NROW];
    logic signed [31:0] layer_b [NROW];
    longint             grad_w  [NROW*NROW];
    longint             grad_b  [NROW];
    int unsigned        samples_in_batch;
    logic [15:0]        cur_batch;
    logic [31:0]        cur_step;

    req_word_t pending_words[$];
    rsp_word_t expected_rsp[$];
    int  errors;
    int  send_idle_pct;
    int  stall_pct;
    int  quiet_cycles;
    bit  req_fire;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint row_score(int r, int c0, longint x0, int c1, longint x1);
        longint acc;
        acc = 0;
        if (c0 < NROW) acc += longint'(layer_w[r*NROW+c0]) * x0;
        if (c1 < NROW) acc += longint'(layer_w[r*NROW+c1]) * x1;
        return longint'(layer_b[r]) + (acc >>> 16);
    endfunction

    function automatic longint step_delta(longint g);
        longint hi_part;
        longint lo_part;
        hi_part = g * longint'(cur_step[31:16]);
        lo_part = g * longint'(cur_step[15:0]);
        return (hi_part + (lo_part >>> 16)) >>> 16;
    endfunction

    function automatic void apply_batch_update();
        for (int i = 0; i < NROW*NROW; i++) begin
            layer_w[i] = sat(longint'(layer_w[i]) - step_delta(grad_w[i]),
                             -64'sd2147483648, 64'sd2147483647);
            grad_w[i] = 0;
        end
        for (int i = 0; i < NROW; i++) begin
            layer_b[i] = sat(longint'(layer_b[i]) - step_delta(grad_b[i]),
                             -64'sd2147483648, 64'sd2147483647);
            grad_b[i] = 0;
        end
        samples_in_batch = 0;
    endfunction

    function automatic rsp_word_t predict_response(req_word_t w);
        rsp_word_t o;
        int     c0, c1, tgt, k;
        longint x0, x1, e, s, best;
        o  = '0;
        c0 = int'(w.sample >> 16);
        c1 = c0 + 1;
        x1 = longint'(w.sample[15:0]);
        x0 = ONE_Q - x1;
        tgt = int'((32'(w.sample) + 32'h8000) >> 16);
        if (w.mode == MODE_TRAIN) begin
            for (int r = 0; r < NROW; r++) begin
                e = row_score(r, c0, x0, c1, x1) - (r == tgt ? ONE_Q : 0);
                if (c0 < NROW) begin
                    k = r*NROW + c0;
                    grad_w[k] = sat(grad_w[k] + ((e * x0) >>> 16), GRAD_LO, GRAD_HI);
                end
                if (c1 < NROW) begin
                    k = r*NROW + c1;
                    grad_w[k] = sat(grad_w[k] + ((e * x1) >>> 16), GRAD_LO, GRAD_HI);
                end
                grad_b[r] = sat(grad_b[r] + e, GRAD_LO, GRAD_HI);
            end
            if (samples_in_batch < 65535) samples_in_batch++;
            if (samples_in_batch >= ((cur_batch == 0) ? 1 : cur_batch)) begin
                apply_batch_update();
                o.done = 1'b1;
            end
        end else if (w.mode == MODE_CLASSIFY) begin
            best  = longint'(SCORE_START);
            o.idx = IDX_W'(NROW);
            for (int r = 0; r < NROW; r++) begin
                s = sat(row_score(r, c0, x0, c1, x1), -64'sd2147483648, 64'sd2147483647);
                if (s > best) begin
                    best  = s;
                    o.idx = IDX_W'(r);
                end
            end
            o.score = best[31:0];
        end else if (w.mode == MODE_WRITE) begin
            if (w.col == BIAS_COL)
                layer_b[w.row] = w.wval;
            else if (w.col < COL_W'(NROW))
                layer_w[w.row*NROW + w.col] = w.wval;
        end
        return o;
    endfunction

    function automatic req_word_t make_word(logic [MODE_W-1:0] m, int v, int r, int c,
                                            logic [31:0] wv);
        req_word_t w;
        w.mode   = m;
        w.sample = SAMPLE_W'(v);
        w.row    = ROW_W'(r);
        w.col    = COL_W'(c);
        w.wval   = wv;
        return w;
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        int roll;
        roll = $urandom_range(99);
        w.mode = roll < 55 ? MODE_TRAIN : roll < 85 ? MODE_CLASSIFY :
                 roll < 97 ? MODE_WRITE : MODE_UNUSED;
        w.sample = ($urandom_range(9) == 0) ? SAMPLE_W'($urandom)
                                            : SAMPLE_W'($urandom_range(983039));
        w.row  = ROW_W'($urandom);
        w.col  = ($urandom_range(4) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(16));
        w.wval = ($urandom_range(3) == 0) ? $urandom
                                          : 32'($urandom_range(524287)) - 32'sd262144;
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        if (idx == CFG_BATCH_SIZE) cur_batch = val[15:0];
        else                       cur_step  = val;
    endtask

    // sample at the rising edge, where the queue and valid are both settled
    task automatic drain();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || expected_rsp.size() != 0 || req_ch.valid);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_random(int count, int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count) pending_words.push_back(random_word());
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // request driver: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_fire)) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_word_t w;
                w = pending_words.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.mode         <= w.mode;
                req_ch.sample_value <= w.sample;
                req_ch.target_row   <= w.row;
                req_ch.target_col   <= w.col;
                req_ch.write_value  <= w.wval;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin
        req_fire = req_ch.valid && req_ch.ready;
        if (req_fire)
            expected_rsp.push_back(predict_response(make_word(req_ch.mode,
                int'(req_ch.sample_value), int'(req_ch.target_row),
                int'(req_ch.target_col), req_ch.write_value)));
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: response word with nothing expected");
            end else begin
                rsp_word_t ex;
                ex = expected_rsp.pop_front();
                if (rsp_ch.predicted_index !== ex.idx || rsp_ch.best_score !== ex.score ||
                    rsp_ch.batch_done !== ex.done) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: idx %0d/%0d score %0d/%0d done %0b/%0b (exp/act)",
                                 ex.idx, rsp_ch.predicted_index, ex.score,
                                 rsp_ch.best_score, ex.done, rsp_ch.batch_done);
                end
            end
        end
        if (!rst_n || req_fire || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        quiet_cycles  = 0;
        req_fire      = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = '0;
        req_ch.sample_value = '0;
        req_ch.target_row   = '0;
        req_ch.target_col   = '0;
        req_ch.write_value  = '0;
        rsp_ch.ready        = 1'b0;
        for (int i = 0; i < NROW*NROW; i++) begin
            layer_w[i] = 0;
            grad_w[i]  = 0;
        end
        for (int i = 0; i < NROW; i++) begin
            layer_b[i] = 0;
            grad_b[i]  = 0;
        end
        samples_in_batch = 0;
        cur_batch = BATCH_SIZE_RST;
        cur_step  = STEP_SCALE_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, out-of-range writes, rounding edge, unused mode
        write_reg(CFG_BATCH_SIZE, 32'd3);
        write_reg(CFG_STEP_SCALE, 32'hFFFF_FFFF);
        pending_words.push_back(make_word(MODE_CLASSIFY, 0, 0, 0, 0));
        pending_words.push_back(make_word(MODE_WRITE, 0, 0, 0, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(MODE_WRITE, 0, 15, 15, 32'h8000_0000));
        pending_words.push_back(make_word(MODE_WRITE, 0, 3, 16, 32'h0001_0000));
        pending_words.push_back(make_word(MODE_WRITE, 0, 15, 16, 32'hFC18_0000));
        pending_words.push_back(make_word(MODE_WRITE, 0, 2, 17, 32'h1234_5678));
        pending_words.push_back(make_word(MODE_WRITE, 0, 4, 31, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(MODE_CLASSIFY, 0, 0, 0, 0));
        pending_words.push_back(make_word(MODE_CLASSIFY, 983039, 0, 0, 0));
        pending_words.push_back(make_word(MODE_CLASSIFY, 20'hFFFFF, 0, 0, 0));
        pending_words.push_back(make_word(MODE_CLASSIFY, 20'h0_8000, 0, 0, 0));
        pending_words.push_back(make_word(MODE_UNUSED, 20'h1_0000, 7, 3, 32'h0003_0000));
        pending_words.push_back(make_word(MODE_TRAIN, 0, 0, 0, 0));
        pending_words.push_back(make_word(MODE_TRAIN, 20'h0_7FFF, 0, 0, 0));
        pending_words.push_back(make_word(MODE_TRAIN, 20'hF_8000, 0, 0, 0));
        pending_words.push_back(make_word(MODE_TRAIN, 20'hFFFFF, 0, 0, 0));
        pending_words.push_back(make_word(MODE_TRAIN, 20'hE_FFFF, 0, 0, 0));
        pending_words.push_back(make_word(MODE_CLASSIFY, 20'h0_8000, 0, 0, 0));
        pending_words.push_back(make_word(MODE_WRITE, 0, 0, 0, 32'h0));
        pending_words.push_back(make_word(MODE_WRITE, 0, 15, 15, 32'h0));
        pending_words.push_back(make_word(MODE_CLASSIFY, 20'h3_4000, 0, 0, 0));
        drain();

        write_reg(CFG_BATCH_SIZE, 32'd0);
        write_reg(CFG_STEP_SCALE, 32'd0);
        run_random(30, 0, 0);

        write_reg(CFG_BATCH_SIZE, 32'd65535);
        write_reg(CFG_STEP_SCALE, 32'(STEP_SCALE_RST));
        run_random(150, 79, 0);

        // count is now above the new size, so the next train word closes a batch
        write_reg(CFG_BATCH_SIZE, 32'd5);
        write_reg(CFG_STEP_SCALE, 32'h8000_0000);
        run_random(300, 0, 79);

        write_reg(CFG_BATCH_SIZE, 32'd16);
        write_reg(CFG_STEP_SCALE, $urandom);
        run_random(300, 10, 10);

        write_reg(CFG_BATCH_SIZE, 32'd1);
        write_reg(CFG_STEP_SCALE, 32'h1000_0000);
        run_random(120, 0, 0);

        write_reg(CFG_BATCH_SIZE, 32'($urandom_range(40, 2)));
        write_reg(CFG_STEP_SCALE, $urandom);
        run_random(200, 79, 0);

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
